### hdl/decimal_text_to_binary64_core_assert.svh
// Assertion macros shared by the checker files of the decimal text converter.
// Each macro expands to one labelled concurrent assertion that is disabled
// while the asynchronous reset is asserted.
`ifndef DECIMAL_TEXT_TO_BINARY64_CORE_ASSERT_SVH
`define DECIMAL_TEXT_TO_BINARY64_CORE_ASSERT_SVH
// The consequent must hold in the same cycle as the antecedent.
`define DTB_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define DTB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### hdl/dtb_pkg.sv
// ----------------------------------------------------------------------------
// dtb_pkg
// Types, character codes and extended-precision helpers for the converter.
// ----------------------------------------------------------------------------
package dtb_pkg;

  localparam int unsigned CHAR_W         = 8;
  localparam int unsigned VALUE_W        = 64;
  localparam int unsigned COUNT_W        = 16;
  localparam int unsigned DEF_MAX_DIGITS = 18;
  localparam int unsigned DEF_MAX_EXP    = 441;
  localparam int unsigned DEF_COUNT_BITS = 16;
  localparam int unsigned MAG_W          = 9;
  localparam int unsigned POW5_N         = 9;
  localparam int unsigned XE_W           = 16;
  localparam int unsigned OFF_W          = 17;
  localparam int unsigned EXP_W          = 32;

  // Largest exponent that can take one more digit without leaving 31 bits.
  localparam logic [EXP_W-1:0] GUARD_BASE = 32'd214748363;
  localparam logic [VALUE_W-1:0] INF_BITS = 64'h7FF0_0000_0000_0000;
  localparam logic [VALUE_W-1:0] ONE_NORM = 64'h8000_0000_0000_0000;

  localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'd43;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'd45;
  localparam logic [CHAR_W-1:0] CH_POINT = 8'd46;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'd57;
  localparam logic [CHAR_W-1:0] CH_E_UP  = 8'd69;
  localparam logic [CHAR_W-1:0] CH_E_LO  = 8'd101;

  // Value is m * 2^e with m normalised (top bit set).
  typedef struct packed {
    logic [VALUE_W-1:0]     m;
    logic signed [XE_W-1:0] e;
  } xnum_t;

  typedef struct packed {
    logic               range;
    logic [VALUE_W-1:0] bits;
  } conv_t;

  // Round to nearest even on a 64-bit significand.
  function automatic xnum_t round_x(input logic [VALUE_W-1:0] m, input logic rnd,
                                    input logic sticky, input logic signed [XE_W-1:0] e);
    xnum_t r;
    logic [VALUE_W:0] s;
    r.m = m;
    r.e = e;
    s   = {1'b0, m} + 65'd1;
    if (rnd && (sticky || m[0])) begin
      if (s[VALUE_W]) begin
        r.m = ONE_NORM;
        r.e = e + 16'sd1;
      end else begin
        r.m = s[VALUE_W-1:0];
      end
    end
    return r;
  endfunction

  // 5^(2^idx) rounded to the extended format; evaluated at elaboration only.
  function automatic xnum_t pow5_entry(input int unsigned idx);
    logic [639:0] big;
    logic [639:0] shifted;
    logic [639:0] low_mask;
    int unsigned  t;
    xnum_t        r;
    big = 640'd1;
    t   = 0;
    for (int unsigned k = 0; k < (32'd1 << idx); k++) begin
      big = (big << 2) + big;
    end
    for (int unsigned i = 0; i < 640; i++) begin
      if (big[i]) t = i;
    end
    if (t <= 63) begin
      r.m = big[63:0] << (63 - t);
      r.e = 16'(int'(t) - 63);
    end else begin
      shifted  = big >> (t - 63);
      low_mask = (640'd1 << (t - 64)) - 640'd1;
      r = round_x(shifted[63:0], big[t-64], |(big & low_mask), 16'(int'(t) - 63));
    end
    return r;
  endfunction

  localparam xnum_t POW5_TAB [POW5_N] = '{
    pow5_entry(0), pow5_entry(1), pow5_entry(2), pow5_entry(3), pow5_entry(4),
    pow5_entry(5), pow5_entry(6), pow5_entry(7), pow5_entry(8)
  };

  // Final rounding of the extended value to binary64, sign excluded.
  function automatic conv_t to_binary64(input xnum_t x);
    conv_t                c;
    logic signed [17:0]   ex;
    logic signed [17:0]   s;
    logic [10:0]          r;
    logic [53:0]          q;
    logic [VALUE_W-1:0]   half;
    logic [VALUE_W-1:0]   rem;
    logic [VALUE_W-1:0]   qs;
    c.range = 1'b0;
    c.bits  = '0;
    ex      = 18'(x.e) + 18'sd63;
    s       = -(18'(x.e) + 18'sd1074);
    r       = x.m[10:0];
    q       = {1'b0, x.m[63:11]};
    half    = '0;
    rem     = '0;
    qs      = '0;
    if (ex > 18'sd1023 || (ex == 18'sd1023 && x.m > 64'hFFFF_FFFF_FFFF_F800)) begin
      c.range = 1'b1;
      c.bits  = INF_BITS;
    end else if (ex >= -18'sd1022) begin
      if (r > 11'h400 || (r == 11'h400 && q[0])) q = q + 54'd1;
      if (q[53]) begin
        q  = q >> 1;
        ex = ex + 18'sd1;
      end
      if (ex > 18'sd1023) begin
        c.range = 1'b1;
        c.bits  = INF_BITS;
      end else begin
        c.bits = {1'b0, 11'(ex + 18'sd1023), q[51:0]};
      end
    end else begin
      if (s > 18'sd64) begin
        qs = '0;
      end else if (s == 18'sd64) begin
        qs = (x.m > ONE_NORM) ? 64'd1 : 64'd0;
      end else begin
        half = 64'd1 << 6'(s - 18'sd1);
        rem  = x.m & ((half << 1) - 64'd1);
        qs   = x.m >> 6'(s);
        if (rem > half || (rem == half && qs[0])) qs = qs + 64'd1;
      end
      c.range = (qs == 64'd0);
      c.bits  = qs;
    end
    return c;
  endfunction

endpackage

### hdl/dtb_channel_if.sv
// ----------------------------------------------------------------------------
// dtb channel interfaces
// Valid/ready channels for the character stream and the converted result.
// ----------------------------------------------------------------------------
interface dtb_char_if;
  logic                        valid;
  logic                        ready;
  logic [dtb_pkg::CHAR_W-1:0]  char_code;
  logic                        last_char;
  modport source (output valid, char_code, last_char, input ready);
  modport sink (input valid, char_code, last_char, output ready);
endinterface

interface dtb_res_if;
  logic                        valid;
  logic                        ready;
  logic [dtb_pkg::VALUE_W-1:0] value_bits;
  logic [dtb_pkg::COUNT_W-1:0] consumed_count;
  logic                        range_error;
  modport source (output valid, value_bits, consumed_count, range_error, input ready);
  modport sink (input valid, value_bits, consumed_count, range_error, output ready);
endinterface

### hdl/decimal_text_to_binary64_core.sv
// Characters are taken only while the sequencer is idle. After the last one the result
// is valid straight from the prepare step for a zero mantissa, and otherwise follows the
// one-bit-a-cycle normalising shift, the table multiplies on the shared 32x32 unit (up
// to eight of them) and either the final multiply or the 64-step restoring divide.
// A new string is not taken until the result of the last one has transferred.
// Reset is asynchronous, active low, and returns the parser to the whitespace phase.
// ----------------------------------------------------------------------------
// decimal_text_to_binary64_core
// Streaming decimal text to IEEE binary64 converter with a shared
// multiply/divide unit under a small sequencer.
// ----------------------------------------------------------------------------
module decimal_text_to_binary64_core #(
  parameter int unsigned MAX_DIGITS = dtb_pkg::DEF_MAX_DIGITS,
  parameter int unsigned MAX_EXP    = dtb_pkg::DEF_MAX_EXP,
  parameter int unsigned COUNT_BITS = dtb_pkg::DEF_COUNT_BITS
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  dtb_char_if.sink     char_i,
  dtb_res_if.source    res_o
);
  import dtb_pkg::*;

  localparam int unsigned KEPT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic signed [OFF_W-1:0] OFF_MAX = 17'sd65535;
  localparam logic signed [OFF_W-1:0] OFF_MIN = -17'sd65535;
  localparam logic [3:0] LAST_POW = 4'(POW5_N);

  // Parser phases; the three remaining codes never occur.
  typedef enum logic [2:0] {
    PH_WS, PH_MANT, PH_ESTART, PH_ESIGN, PH_EDIG
  } phase_e;

  // Sequencer states. IDLE is the only state in which characters transfer.
  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_NORM, S_P5SEL, S_MUL, S_MRND, S_DIV, S_DRND, S_CONV, S_OUT
  } state_e;

  // --------------------------------------------------------------------------
  // Parser state
  // --------------------------------------------------------------------------
  phase_e                   phase_q, phase_d;
  logic                     neg_q, neg_d;
  logic [VALUE_W-1:0]       dv_q, dv_d;
  logic [KEPT_W-1:0]        kept_q, kept_d;
  logic signed [OFF_W-1:0]  po_q, po_d;
  logic                     ps_q, ps_d;
  logic [EXP_W-1:0]         ev_q, ev_d;
  logic                     eneg_q, eneg_d;
  logic [COUNT_BITS-1:0]    pos_q, pos_d;
  logic [COUNT_BITS-1:0]    mend_q, mend_d;
  logic                     done_q, done_d;
  logic                     seen_q, seen_d;

  // --------------------------------------------------------------------------
  // Sequencer and datapath registers
  // --------------------------------------------------------------------------
  state_e                   st_q;
  logic [5:0]               cnt_q;
  logic [3:0]               idx_q;
  logic [MAG_W-1:0]         mag_q;
  logic                     down_q;
  logic                     final_q;
  logic                     range_q;
  logic [VALUE_W-1:0]       xm_q;
  logic signed [XE_W-1:0]   xe_q;
  logic [VALUE_W-1:0]       ma_q;
  logic [VALUE_W-1:0]       mb_q;
  logic signed [XE_W-1:0]   me_q;
  logic [2*VALUE_W-1:0]     acc_q;
  logic [VALUE_W-1:0]       pp_q;
  logic [1:0]               sh_q;
  logic [VALUE_W-1:0]       rr_q;
  logic                     rc_q;
  logic [VALUE_W-1:0]       qq_q;
  logic [VALUE_W-1:0]       res_bits_q;

  logic char_take;
  logic res_take;

  assign char_i.ready = (st_q == S_IDLE);
  assign char_take    = char_i.valid && char_i.ready;
  assign res_o.valid  = (st_q == S_OUT);
  assign res_take     = res_o.valid && res_o.ready;

  assign res_o.value_bits     = res_bits_q;
  assign res_o.consumed_count = seen_q ? COUNT_W'(mend_q) : '0;
  assign res_o.range_error    = range_q;

  // --------------------------------------------------------------------------
  // Character classification and the exponent overflow guard. The guard is
  // the exponent limit minus the point offset, negated for a negative exponent,
  // divided by ten (truncating), where the division is a multiply by a
  // reciprocal that is exact for 16-bit magnitudes.
  // --------------------------------------------------------------------------
  logic [CHAR_W-1:0]  ch;
  logic               is_digit;
  logic               is_ws;
  logic               is_plus;
  logic               is_minus;
  logic [3:0]         dig;
  logic [COUNT_BITS-1:0] pos_next;
  logic [15:0]        po_abs;
  logic [31:0]        po_recip;
  logic [15:0]        po_tenth;
  logic               so_neg;
  logic [EXP_W-1:0]   guard;

  assign ch       = char_i.char_code;
  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign is_ws    = (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  assign is_plus  = (ch == CH_PLUS);
  assign is_minus = (ch == CH_MINUS);
  assign dig      = 4'(ch - CH_ZERO);
  assign pos_next = (pos_q == COUNT_MAX) ? pos_q : pos_q + 1'b1;
  assign po_abs   = po_q[OFF_W-1] ? 16'(-po_q) : 16'(po_q);
  assign po_recip = 32'(po_abs) * 32'd52429;
  assign po_tenth = 16'(po_recip >> 19);
  assign so_neg   = eneg_q ^ po_q[OFF_W-1];
  assign guard    = so_neg ? GUARD_BASE + 32'(po_tenth) : GUARD_BASE - 32'(po_tenth);

  always_comb begin
    logic mant;
    logic expo;
    phase_d = phase_q;
    neg_d   = neg_q;
    dv_d    = dv_q;
    kept_d  = kept_q;
    po_d    = po_q;
    ps_d    = ps_q;
    ev_d    = ev_q;
    eneg_d  = eneg_q;
    pos_d   = pos_q;
    mend_d  = mend_q;
    done_d  = done_q;
    seen_d  = seen_q;
    mant    = 1'b0;
    expo    = 1'b0;
    if (char_take) begin
      pos_d = pos_next;
      if (!done_q) begin
        case (phase_q)
          PH_WS: begin
            if (!is_ws) begin
              phase_d = PH_MANT;
              if (is_minus) begin
                neg_d = 1'b1;
              end else if (!is_plus) begin
                mant = 1'b1;
              end
            end
          end
          PH_MANT: begin
            mant = 1'b1;
          end
          default: begin
            expo = 1'b1;
          end
        endcase
      end
      if (mant) begin
        if (is_digit) begin
          seen_d = 1'b1;
          mend_d = pos_next;
          if (kept_q < KEPT_W'(MAX_DIGITS)) begin
            if (kept_q != '0 || dig != 4'd0) begin
              dv_d   = (dv_q << 3) + (dv_q << 1) + VALUE_W'(dig);
              kept_d = kept_q + 1'b1;
            end
            if (ps_q && po_q > OFF_MIN) po_d = po_q - 1'b1;
          end else if (!ps_q && po_q < OFF_MAX) begin
            po_d = po_q + 1'b1;
          end
        end else if (ch == CH_POINT && !ps_q) begin
          ps_d   = 1'b1;
          mend_d = pos_next;
        end else if (seen_q && (ch == CH_E_LO || ch == CH_E_UP)) begin
          phase_d = PH_ESTART;
        end else begin
          done_d = 1'b1;
        end
      end
      if (expo) begin
        if (phase_q == PH_ESTART && (is_plus || is_minus)) begin
          eneg_d  = is_minus;
          phase_d = PH_ESIGN;
        end else if (is_digit) begin
          if (ev_q <= guard) ev_d = (ev_q << 3) + (ev_q << 1) + EXP_W'(dig);
          phase_d = PH_EDIG;
          mend_d  = pos_next;
        end else begin
          if (phase_q != PH_EDIG) begin
            ev_d   = '0;
            eneg_d = 1'b0;
          end
          done_d = 1'b1;
        end
      end
    end
    // The parser returns to its reset state once the result has transferred.
    if (res_take) begin
      phase_d = PH_WS;
      neg_d   = 1'b0;
      dv_d    = '0;
      kept_d  = '0;
      po_d    = '0;
      ps_d    = 1'b0;
      ev_d    = '0;
      eneg_d  = 1'b0;
      pos_d   = '0;
      mend_d  = '0;
      done_d  = 1'b0;
      seen_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WS;
      neg_q   <= 1'b0;
      dv_q    <= '0;
      kept_q  <= '0;
      po_q    <= '0;
      ps_q    <= 1'b0;
      ev_q    <= '0;
      eneg_q  <= 1'b0;
      pos_q   <= '0;
      mend_q  <= '0;
      done_q  <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      dv_q    <= dv_d;
      kept_q  <= kept_d;
      po_q    <= po_d;
      ps_q    <= ps_d;
      ev_q    <= ev_d;
      eneg_q  <= eneg_d;
      pos_q   <= pos_d;
      mend_q  <= mend_d;
      done_q  <= done_d;
      seen_q  <= seen_d;
    end
  end

  // --------------------------------------------------------------------------
  // Decimal exponent of the string. An exponent marker without digits is
  // dropped, then the point offset is folded in and the magnitude clamped.
  // --------------------------------------------------------------------------
  logic               drop_exp;
  logic [EXP_W-1:0]   eff_ev;
  logic               eff_neg;
  logic signed [33:0] po_ext;
  logic signed [33:0] so_ext;
  logic signed [33:0] tot_raw;
  logic signed [33:0] tot;
  logic [33:0]        tot_abs;
  logic               clamp;

  assign drop_exp = !done_q && (phase_q == PH_ESTART || phase_q == PH_ESIGN);
  assign eff_ev   = drop_exp ? '0 : ev_q;
  assign eff_neg  = eneg_q && !drop_exp;
  assign po_ext   = 34'(po_q);
  assign so_ext   = eff_neg ? -po_ext : po_ext;
  assign tot_raw  = $signed({2'b00, eff_ev}) + so_ext;
  assign tot      = eff_neg ? -tot_raw : tot_raw;
  assign tot_abs  = tot[33] ? 34'(-tot) : 34'(tot);
  assign clamp    = tot_abs > 34'(MAX_EXP);

  // --------------------------------------------------------------------------
  // Shared arithmetic: one 32x32 multiplier walked over the four partial
  // products, the restoring divide step, and the rounding of both results.
  // --------------------------------------------------------------------------
  logic [31:0]          mul_a;
  logic [31:0]          mul_b;
  logic [VALUE_W-1:0]   prod;
  logic [2*VALUE_W-1:0] acc_add;
  logic [1:0]           sh_next;
  logic [VALUE_W-1:0]   hi;
  logic [VALUE_W-1:0]   lo;
  xnum_t                mul_rx;
  logic                 div_ge;
  logic [VALUE_W-1:0]   div_rem;
  logic                 div_rnd;
  xnum_t                div_rx;
  logic signed [XE_W-1:0] div_e0;
  logic signed [XE_W-1:0] mag_s;
  conv_t                cv;

  assign mul_a   = cnt_q[1] ? ma_q[63:32] : ma_q[31:0];
  assign mul_b   = cnt_q[0] ? mb_q[63:32] : mb_q[31:0];
  assign prod    = mul_a * mul_b;
  assign sh_next = (cnt_q == 6'd0) ? 2'd0 : ((cnt_q == 6'd3) ? 2'd2 : 2'd1);
  assign hi      = acc_q[127:64];
  assign lo      = acc_q[63:0];
  assign mag_s   = $signed({{(XE_W-MAG_W){1'b0}}, mag_q});
  assign div_e0  = xe_q - me_q - 16'sd63;

  always_comb begin
    case (sh_q)
      2'd0:    acc_add = {64'd0, pp_q};
      2'd1:    acc_add = {32'd0, pp_q, 32'd0};
      default: acc_add = {pp_q, 64'd0};
    endcase
  end

  assign mul_rx = hi[63] ? round_x(hi, lo[63], |lo[62:0], me_q + 16'sd64)
                         : round_x({hi[62:0], lo[63]}, lo[62], |lo[61:0], me_q + 16'sd63);

  assign div_ge  = rc_q || (rr_q >= ma_q);
  assign div_rem = div_ge ? rr_q - ma_q : rr_q;
  assign div_rnd = div_ge;
  assign div_rx  = round_x(qq_q, div_rnd, div_rnd && (rc_q || rr_q != ma_q), me_q);

  assign cv = to_binary64('{m: xm_q, e: xe_q});

  // --------------------------------------------------------------------------
  // Sequencer. After the last character: prepare the exponent, normalise
  // the digits one bit a cycle, build the power of five from the table
  // entries chosen by the bits of the exponent magnitude, then either divide
  // or multiply, and round once to binary64. The power of five is kept in
  // the multiplier's first operand register between products.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= S_IDLE;
      cnt_q      <= '0;
      idx_q      <= '0;
      mag_q      <= '0;
      down_q     <= 1'b0;
      final_q    <= 1'b0;
      range_q    <= 1'b0;
      xm_q       <= '0;
      xe_q       <= '0;
      ma_q       <= '0;
      mb_q       <= '0;
      me_q       <= '0;
      acc_q      <= '0;
      pp_q       <= '0;
      sh_q       <= '0;
      rr_q       <= '0;
      rc_q       <= 1'b0;
      qq_q       <= '0;
      res_bits_q <= '0;
    end else begin
      case (st_q)
        S_IDLE: begin
          if (char_take && char_i.last_char) st_q <= S_PREP;
        end
        S_PREP: begin
          if (dv_q == '0) begin
            // Zero or missing mantissa: signed zero, no range error.
            res_bits_q <= {neg_q, 63'd0};
            range_q    <= 1'b0;
            st_q       <= S_OUT;
          end else begin
            xm_q    <= dv_q;
            xe_q    <= '0;
            down_q  <= tot[33];
            mag_q   <= clamp ? MAG_W'(MAX_EXP) : tot_abs[MAG_W-1:0];
            range_q <= clamp;
            st_q    <= S_NORM;
          end
        end
        S_NORM: begin
          if (xm_q[63]) begin
            ma_q    <= ONE_NORM;
            me_q    <= -16'sd63;
            idx_q   <= '0;
            final_q <= 1'b0;
            st_q    <= S_P5SEL;
          end else begin
            xm_q <= xm_q << 1;
            xe_q <= xe_q - 16'sd1;
          end
        end
        S_P5SEL: begin
          if (idx_q == LAST_POW) begin
            if (down_q) begin
              qq_q  <= '0;
              cnt_q <= '0;
              if (xm_q < ma_q) begin
                rc_q <= xm_q[63];
                rr_q <= xm_q << 1;
                me_q <= div_e0 - 16'sd1;
              end else begin
                rc_q <= 1'b0;
                rr_q <= xm_q;
                me_q <= div_e0;
              end
              st_q <= S_DIV;
            end else begin
              mb_q    <= xm_q;
              me_q    <= me_q + xe_q;
              final_q <= 1'b1;
              acc_q   <= '0;
              cnt_q   <= '0;
              st_q    <= S_MUL;
            end
          end else if (mag_q[idx_q]) begin
            mb_q  <= POW5_TAB[idx_q].m;
            me_q  <= me_q + POW5_TAB[idx_q].e;
            acc_q <= '0;
            cnt_q <= '0;
            st_q  <= S_MUL;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_MUL: begin
          if (cnt_q != 6'd0) acc_q <= acc_q + acc_add;
          if (cnt_q == 6'd4) begin
            st_q <= S_MRND;
          end else begin
            pp_q  <= prod;
            sh_q  <= sh_next;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_MRND: begin
          if (final_q) begin
            xm_q <= mul_rx.m;
            xe_q <= mul_rx.e + mag_s;
            st_q <= S_CONV;
          end else begin
            ma_q  <= mul_rx.m;
            me_q  <= mul_rx.e;
            idx_q <= idx_q + 1'b1;
            st_q  <= S_P5SEL;
          end
        end
        S_DIV: begin
          qq_q  <= {qq_q[62:0], div_ge};
          rc_q  <= div_rem[63];
          rr_q  <= div_rem << 1;
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == 6'd63) st_q <= S_DRND;
        end
        S_DRND: begin
          xm_q <= div_rx.m;
          xe_q <= div_rx.e - mag_s;
          st_q <= S_CONV;
        end
        S_CONV: begin
          res_bits_q <= cv.bits | {neg_q, 63'd0};
          range_q    <= range_q | cv.range;
          st_q       <= S_OUT;
        end
        S_OUT: begin
          if (res_take) st_q <= S_IDLE;
        end
        default: begin
          st_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hdl/dtb_checker.sv
// ----------------------------------------------------------------------------
// dtb_checker
// Port-level assertions for the decimal text converter, bound to the core.
// ----------------------------------------------------------------------------
`include "decimal_text_to_binary64_core_assert.svh"

module dtb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [63:0] value_bits_i,
  input logic [15:0] count_i,
  input logic        range_i
);

  // A final character starts the scaling, so no transfer follows at once.
  `DTB_ASSERT_NEXT(a_busy_after_last, clk_i, rst_ni, in_valid_i && in_ready_i && in_last_i, !in_ready_i, "character taken straight after the final one")

  // A waiting result blocks the character side.
  `DTB_ASSERT_SAME(a_one_string, clk_i, rst_ni, out_valid_i, !in_ready_i, "character side open while a result waits")

  // A stalled result holds its payload.
  `DTB_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(value_bits_i) && $stable(count_i) && $stable(range_i), "stalled result changed")

  // Nothing consumed means a signed zero without a range error.
  `DTB_ASSERT_SAME(a_empty_zero, clk_i, rst_ni, out_valid_i && count_i == 16'd0, value_bits_i[62:0] == 63'd0 && !range_i, "empty parse gave a non-zero value")

endmodule

bind decimal_text_to_binary64_core dtb_checker u_dtb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (char_i.valid),
  .in_ready_i   (char_i.ready),
  .in_last_i    (char_i.last_char),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .value_bits_i (res_o.value_bits),
  .count_i      (res_o.consumed_count),
  .range_i      (res_o.range_error)
);
